[rtl/core/lsm_pkg.sv]
// Shared types and constants for the line substring matcher.
package lsm_pkg;

   // Widths fixed by the request and result fields
   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 64;
   localparam int LEN_W   = 5;
   localparam int COUNT_W = 16;
   localparam int KEPT_W  = 8;
   localparam int IDX_W   = 2;

   // Pattern storage spans two 64-bit registers
   localparam int PAT_BYTES = 16;
   localparam int PAT_IDX_W = 4;

   // Bytes that close a line
   localparam logic [BYTE_W-1:0] BYTE_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] BYTE_NUL     = 8'h00;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   // Configuration register indexes
   typedef enum logic [IDX_W-1:0] {
      REG_PATTERN_LOW  = 2'd0,
      REG_PATTERN_HIGH = 2'd1,
      REG_PATTERN_LEN  = 2'd2
   } reg_index_type;

   // One result as held in the output stages
   typedef struct packed {
      logic [COUNT_W-1:0] line_number;
      logic               line_matched;
      logic [KEPT_W-1:0]  kept_length;
      logic [COUNT_W-1:0] match_total;
      logic               final_line;
   } result_type;

endpackage

[rtl/core/lsm_cell.sv]
// One window cell: holds a recent byte, shifts it on, and compares its next value.
module lsm_cell (
   input  logic                        clock,
   input  logic                        shift_en,
   input  logic                        clear,
   input  logic [lsm_pkg::BYTE_W-1:0]  shift_in,
   input  logic [lsm_pkg::BYTE_W-1:0]  pattern_byte,
   input  logic                        cell_used,
   output logic [lsm_pkg::BYTE_W-1:0]  byte_out,
   output logic                        hit
);

   logic [lsm_pkg::BYTE_W-1:0] byte_ff;
   logic [lsm_pkg::BYTE_W-1:0] byte_in;

   // Next content of this cell
   always_comb begin
      if (clear) begin
         byte_in = '0;
      end else if (shift_en) begin
         byte_in = shift_in;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // Compare the byte that arrives with this shift; cells past the pattern always hit
   assign hit      = !cell_used || (shift_in == pattern_byte);
   assign byte_out = byte_ff;

endmodule

[rtl/core/line_substring_matcher_core.sv]
// Top level of the line substring matcher: cell chain, line counters and result skid.
//
// The block takes one file byte per request and can accept a request in every cycle.
// A newline, a zero byte or the end mark closes the line and yields one response,
// registered in the response register or in the skid entry; other bytes yield none.
// All PATTERN_MAX pattern bytes are compared at once by a chain of window cells, so
// the rate is one byte per cycle while req_stall is low. A two-entry output (response
// register plus one skid entry) lets requests flow while a response waits; req_stall
// rises only when both entries are full. Only the first LINE_KEEP bytes of a line take
// part in the search. Line and match counts saturate at 65535; after the end mark the
// counters and window restart for a new file; the pattern registers keep their values.
module line_substring_matcher_core #(
   parameter int PATTERN_MAX = 16,
   parameter int LINE_KEEP   = 255
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lsm_pkg::BYTE_W-1:0]    req_text_byte,
   input  logic                          req_end_mark,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lsm_pkg::COUNT_W-1:0]   rsp_line_number,
   output logic                          rsp_line_matched,
   output logic [lsm_pkg::KEPT_W-1:0]    rsp_kept_length,
   output logic [lsm_pkg::COUNT_W-1:0]   rsp_match_total,
   output logic                          rsp_final_line,
   // configuration port
   input  logic                          csr_write,
   input  logic [lsm_pkg::IDX_W-1:0]     csr_index,
   input  logic [lsm_pkg::WORD_W-1:0]    csr_data
);

   // Configuration registers
   logic [lsm_pkg::WORD_W-1:0] pat_low_ff;
   logic [lsm_pkg::WORD_W-1:0] pat_high_ff;
   logic [lsm_pkg::LEN_W-1:0]  pat_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= lsm_pkg::LEN_W'(1);
      end else if (csr_write) begin
         case (lsm_pkg::reg_index_type'(csr_index))
            lsm_pkg::REG_PATTERN_LOW:  pat_low_ff  <= csr_data;
            lsm_pkg::REG_PATTERN_HIGH: pat_high_ff <= csr_data;
            lsm_pkg::REG_PATTERN_LEN:  pat_len_ff  <= csr_data[lsm_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective pattern length, capped at the window depth
   logic [lsm_pkg::LEN_W-1:0] used_len;
   assign used_len = (pat_len_ff > lsm_pkg::LEN_W'(PATTERN_MAX))
                   ? lsm_pkg::LEN_W'(PATTERN_MAX) : pat_len_ff;

   // Pattern bytes in order
   logic [lsm_pkg::BYTE_W-1:0] pat_bytes [lsm_pkg::PAT_BYTES];
   always_comb begin
      for (int k = 0; k < lsm_pkg::PAT_BYTES; k++) begin
         if (k < 8) begin
            pat_bytes[k] = pat_low_ff[8*k +: 8];
         end else begin
            pat_bytes[k] = pat_high_ff[8*(k-8) +: 8];
         end
      end
   end

   // Handshake and byte classification
   logic skid_valid_ff;
   logic req_accept;
   logic closes_line;
   logic keep_byte;

   logic [lsm_pkg::KEPT_W-1:0]  kept_ff;
   logic                        found_ff;
   logic [lsm_pkg::COUNT_W-1:0] line_ff;
   logic [lsm_pkg::COUNT_W-1:0] match_ff;

   assign req_stall   = skid_valid_ff;
   assign req_accept  = req_valid && !req_stall;
   assign closes_line = req_end_mark || (req_text_byte == lsm_pkg::BYTE_NEWLINE)
                        || (req_text_byte == lsm_pkg::BYTE_NUL);
   assign keep_byte   = req_accept && !closes_line
                        && (kept_ff < lsm_pkg::KEPT_W'(LINE_KEEP));

   // Window cell chain; cell j holds the byte j places back
   logic [lsm_pkg::BYTE_W-1:0] cell_byte [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]     cell_hit;
   logic                       clear_window;

   assign clear_window = reset || (req_accept && closes_line);

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      logic [lsm_pkg::LEN_W-1:0]  align_idx;
      logic [lsm_pkg::BYTE_W-1:0] chain_in;

      // Cell j meets pattern byte used_len-1-j
      assign align_idx = used_len - lsm_pkg::LEN_W'(1) - lsm_pkg::LEN_W'(j);

      if (j == 0) begin : g_head
         assign chain_in = req_text_byte;
      end else begin : g_body
         assign chain_in = cell_byte[j-1];
      end

      lsm_cell u_cell (
         .clock        (clock),
         .shift_en     (keep_byte),
         .clear        (clear_window),
         .shift_in     (chain_in),
         .pattern_byte (pat_bytes[align_idx[lsm_pkg::PAT_IDX_W-1:0]]),
         .cell_used    (lsm_pkg::LEN_W'(j) < used_len),
         .byte_out     (cell_byte[j]),
         .hit          (cell_hit[j])
      );
   end

   // Match after this byte: all cells agree and the line is long enough
   logic [lsm_pkg::KEPT_W-1:0] kept_inc;
   logic                       window_match;

   assign kept_inc     = kept_ff + lsm_pkg::KEPT_W'(1);
   assign window_match = (used_len != '0) && (&cell_hit)
                         && (kept_inc >= lsm_pkg::KEPT_W'(used_len));

   // Line close: result and counter updates
   logic                        line_matched;
   logic [lsm_pkg::COUNT_W-1:0] match_next;
   lsm_pkg::result_type         new_result;

   assign line_matched = found_ff || (used_len == '0);
   assign match_next   = (line_matched && (match_ff != lsm_pkg::COUNT_MAX))
                       ? match_ff + lsm_pkg::COUNT_W'(1) : match_ff;

   always_comb begin
      new_result.line_number  = line_ff;
      new_result.line_matched = line_matched;
      new_result.kept_length  = kept_ff;
      new_result.match_total  = match_next;
      new_result.final_line   = req_end_mark;
   end

   // Per-line and per-file state
   logic [lsm_pkg::KEPT_W-1:0]  kept_in;
   logic                        found_in;
   logic [lsm_pkg::COUNT_W-1:0] line_in;
   logic [lsm_pkg::COUNT_W-1:0] match_in;

   always_comb begin
      kept_in  = kept_ff;
      found_in = found_ff;
      line_in  = line_ff;
      match_in = match_ff;
      if (req_accept && closes_line) begin
         kept_in  = '0;
         found_in = 1'b0;
         if (req_end_mark) begin
            line_in  = lsm_pkg::COUNT_W'(1);
            match_in = '0;
         end else begin
            match_in = match_next;
            if (line_ff != lsm_pkg::COUNT_MAX) begin
               line_in = line_ff + lsm_pkg::COUNT_W'(1);
            end
         end
      end else if (keep_byte) begin
         kept_in = kept_inc;
         if (window_match) begin
            found_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff  <= '0;
         found_ff <= 1'b0;
         line_ff  <= lsm_pkg::COUNT_W'(1);
         match_ff <= '0;
      end else begin
         kept_ff  <= kept_in;
         found_ff <= found_in;
         line_ff  <= line_in;
         match_ff <= match_in;
      end
   end

   // Output register with one skid entry behind it
   logic                rsp_valid_ff;
   lsm_pkg::result_type rsp_ff;
   lsm_pkg::result_type skid_ff;
   logic                new_valid;
   logic                out_free;

   assign new_valid = req_accept && closes_line;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= new_valid;
         end
      end else if (new_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
         end else if (new_valid) begin
            rsp_ff <= new_result;
         end
      end else if (new_valid) begin
         skid_ff <= new_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_number  = rsp_ff.line_number;
   assign rsp_line_matched = rsp_ff.line_matched;
   assign rsp_kept_length  = rsp_ff.kept_length;
   assign rsp_match_total  = rsp_ff.match_total;
   assign rsp_final_line   = rsp_ff.final_line;

`ifndef SYNTHESIS
   // The skid entry is only ever filled behind a held response
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid without a pending response");

   // The end mark restarts line and match counting
   a_file_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_end_mark) |=> (line_ff == lsm_pkg::COUNT_W'(1)) && (match_ff == '0))
      else $error("counters not restarted after end mark");

   // The kept byte count never passes the line limit
   a_kept_limit: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= lsm_pkg::KEPT_W'(LINE_KEEP))
      else $error("kept byte count beyond line limit");

   // A line close always yields a response on the next cycle or in the skid entry
   a_close_lands: assert property (@(posedge clock) disable iff (reset)
      new_valid |=> (rsp_valid_ff || skid_valid_ff))
      else $error("line close produced no response");
`endif

endmodule

[tb/line_substring_matcher_core_test.sv]
// Self-checking testbench for line_substring_matcher_core: queued byte stream, line report check.
module line_substring_matcher_core_test;

   localparam int PATTERN_MAX        = 16;
   localparam int LINE_KEEP          = 255;
   localparam int IDLE_PERCENT       = 27;
   localparam int SETTLE_CYCLES      = 4;
   localparam int WATCHDOG_LIMIT     = 2000;
   localparam int REPORT_LIMIT       = 10;
   localparam int RANDOM_PHASE_ITEMS = 20;

   // Index with no register behind it; writes to it must be ignored
   localparam logic [lsm_pkg::IDX_W-1:0]  REG_UNMAPPED = 2'd3;
   localparam logic [lsm_pkg::BYTE_W-1:0] BYTE_FILL    = 8'h7A;
   localparam logic [lsm_pkg::BYTE_W-1:0] BYTE_LOWER_A = 8'h61;

   typedef struct packed {
      logic [lsm_pkg::BYTE_W-1:0] text;
      logic                       eof;
   } text_request_type;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic [lsm_pkg::BYTE_W-1:0]    req_text_byte = '0;
   logic                          req_end_mark  = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   logic [lsm_pkg::COUNT_W-1:0]   rsp_line_number;
   logic                          rsp_line_matched;
   logic [lsm_pkg::KEPT_W-1:0]    rsp_kept_length;
   logic [lsm_pkg::COUNT_W-1:0]   rsp_match_total;
   logic                          rsp_final_line;
   logic                          csr_write     = 1'b0;
   logic [lsm_pkg::IDX_W-1:0]     csr_index     = '0;
   logic [lsm_pkg::WORD_W-1:0]    csr_data      = '0;

   line_substring_matcher_core uut (.*);

   always #5 clock = ~clock;

   // Matcher state as the block should hold it
   logic [lsm_pkg::BYTE_W-1:0]  window_bytes [PATTERN_MAX];
   int                          kept_bytes;
   bit                          line_found;
   logic [lsm_pkg::COUNT_W-1:0] line_count;
   logic [lsm_pkg::COUNT_W-1:0] match_count;
   logic [lsm_pkg::WORD_W-1:0]  pattern_low;
   logic [lsm_pkg::WORD_W-1:0]  pattern_high;
   logic [lsm_pkg::LEN_W-1:0]   pattern_len;

   text_request_type    pending_requests [$];
   lsm_pkg::result_type expected_lines [$];
   text_request_type    next_request;
   text_request_type    taken_request;
   lsm_pkg::result_type line_due;
   lsm_pkg::result_type line_seen;

   int idle_percent = IDLE_PERCENT;
   bit req_taken;
   int quiet_cycles;
   int mismatch_count;
   int lines_checked;
   int matched_lines;
   int requests_accepted;
   int items_queued;
   int register_writes;

   task automatic clear_line();
      foreach (window_bytes[i]) window_bytes[i] = '0;
      kept_bytes = 0;
      line_found = 1'b0;
   endtask

   // Advance the matcher by one request; a closed line queues its report
   task automatic scan_request(input text_request_type item);
      int                           used;
      bit                           hit;
      logic [2*lsm_pkg::WORD_W-1:0] pattern_word;
      lsm_pkg::result_type          report;
      used = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : int'(pattern_len);
      pattern_word = {pattern_high, pattern_low};
      if (!item.eof && item.text != lsm_pkg::BYTE_NEWLINE && item.text != lsm_pkg::BYTE_NUL) begin
         // bytes past the keep limit are dropped unseen
         if (kept_bytes < LINE_KEEP) begin
            for (int i = PATTERN_MAX - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
            window_bytes[0] = item.text;
            kept_bytes++;
            if (used > 0 && kept_bytes >= used) begin
               hit = 1'b1;
               for (int k = 0; k < used; k++) begin
                  if (window_bytes[used-1-k] != pattern_word[8*k +: 8]) hit = 1'b0;
               end
               if (hit) line_found = 1'b1;
            end
         end
      end else begin
         // empty pattern matches every line
         hit = line_found || used == 0;
         if (hit && match_count != lsm_pkg::COUNT_MAX) match_count++;
         report.line_number  = line_count;
         report.line_matched = hit;
         report.kept_length  = lsm_pkg::KEPT_W'(kept_bytes);
         report.match_total  = match_count;
         report.final_line   = item.eof;
         expected_lines.push_back(report);
         clear_line();
         if (item.eof) begin
            line_count  = lsm_pkg::COUNT_W'(1);
            match_count = '0;
         end else if (line_count != lsm_pkg::COUNT_MAX) begin
            line_count++;
         end
      end
   endtask

   // Request driver: holds a stalled request, otherwise idles at random
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_percent) begin
            next_request = pending_requests.pop_front();
            req_valid     <= 1'b1;
            req_text_byte <= next_request.text;
            req_end_mark  <= next_request.eof;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < idle_percent);
   end

   // Monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      if (reset) begin
         req_taken    = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            taken_request = '{text: req_text_byte, eof: req_end_mark};
            scan_request(taken_request);
            requests_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            lines_checked++;
            if (rsp_line_matched) matched_lines++;
            line_seen = '{rsp_line_number, rsp_line_matched, rsp_kept_length,
                          rsp_match_total, rsp_final_line};
            if (expected_lines.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"unexpected line report: line %0d match %0b kept %0d ",
                            "total %0d final %0b"},
                           rsp_line_number, rsp_line_matched, rsp_kept_length,
                           rsp_match_total, rsp_final_line);
            end else begin
               line_due = expected_lines.pop_front();
               if (line_due !== line_seen) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"line report mismatch: expected line %0d match %0b kept %0d ",
                               "total %0d final %0b, got line %0d match %0b kept %0d ",
                               "total %0d final %0b"},
                              line_due.line_number, line_due.line_matched,
                              line_due.kept_length, line_due.match_total, line_due.final_line,
                              line_seen.line_number, line_seen.line_matched,
                              line_seen.kept_length, line_seen.match_total,
                              line_seen.final_line);
               end
            end
         end
         quiet_cycles = (req_taken || (rsp_valid && !rsp_stall)) ? 0 : quiet_cycles + 1;
      end
   end

   // Watchdog on cycles without any transfer
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no transfer for %0d cycles, %0d line reports outstanding",
               WATCHDOG_LIMIT, expected_lines.size());
      $display("Some tests failed");
      $finish;
   end

   task automatic write_reg(input logic [lsm_pkg::IDX_W-1:0] index,
                            input logic [lsm_pkg::WORD_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      register_writes++;
      case (index)
         lsm_pkg::REG_PATTERN_LOW:  pattern_low  = value;
         lsm_pkg::REG_PATTERN_HIGH: pattern_high = value;
         lsm_pkg::REG_PATTERN_LEN:  pattern_len  = value[lsm_pkg::LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_pattern(input logic [2*lsm_pkg::WORD_W-1:0] bytes,
                              input logic [lsm_pkg::LEN_W-1:0] len);
      write_reg(lsm_pkg::REG_PATTERN_LOW, bytes[lsm_pkg::WORD_W-1:0]);
      write_reg(lsm_pkg::REG_PATTERN_HIGH, bytes[2*lsm_pkg::WORD_W-1:lsm_pkg::WORD_W]);
      write_reg(lsm_pkg::REG_PATTERN_LEN, lsm_pkg::WORD_W'(len));
   endtask

   function automatic logic [2*lsm_pkg::WORD_W-1:0] pack_text(input string s);
      logic [2*lsm_pkg::WORD_W-1:0] word;
      word = '0;
      for (int i = 0; i < s.len() && i < PATTERN_MAX; i++) word[8*i +: 8] = s[i];
      return word;
   endfunction

   task automatic push_request(input logic [lsm_pkg::BYTE_W-1:0] text, input logic eof);
      pending_requests.push_back('{text: text, eof: eof});
      items_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_request(s[i], 1'b0);
   endtask

   task automatic push_repeat(input logic [lsm_pkg::BYTE_W-1:0] text, input int count);
      for (int i = 0; i < count; i++) push_request(text, 1'b0);
   endtask

   task automatic push_pattern(input logic [2*lsm_pkg::WORD_W-1:0] bytes, input int count);
      for (int i = 0; i < count; i++) push_request(bytes[8*i +: 8], 1'b0);
   endtask

   // Block idle: every queued request taken, all reports back, pipeline settled
   task automatic wait_idle();
      while (requests_accepted != items_queued || expected_lines.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One line of random content, often with the pattern planted in it
   task automatic push_random_line(input int used, input logic [2*lsm_pkg::WORD_W-1:0] bytes);
      int                         pick;
      int                         count;
      int                         pos;
      bit                         plant;
      logic [lsm_pkg::BYTE_W-1:0] text;
      pick  = $urandom_range(0, 99);
      count = (pick < 89) ? $urandom_range(0, 20) :
              (pick < 99) ? $urandom_range(21, 80) : $urandom_range(250, 270);
      plant = used > 0 && used <= count && $urandom_range(0, 1);
      pos   = plant ? $urandom_range(0, count - used) : 0;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (plant && i >= pos && i < pos + used)
            text = bytes[8*(i-pos) +: 8];
         else if (pick < 8)
            text = lsm_pkg::BYTE_W'($urandom_range(0, 255));
         else if (pick < 60 && used > 0)
            text = bytes[8*$urandom_range(0, used - 1) +: 8];
         else
            text = lsm_pkg::BYTE_W'(BYTE_LOWER_A + $urandom_range(0, 3));
         push_request(text, 1'b0);
      end
      // line terminator: newline, zero byte or end of file
      pick = $urandom_range(0, 99);
      if (pick < 70)
         push_request(lsm_pkg::BYTE_NEWLINE, 1'b0);
      else if (pick < 88)
         push_request(lsm_pkg::BYTE_NUL, 1'b0);
      else
         push_request(lsm_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic run_random_phase(input logic [lsm_pkg::LEN_W-1:0] len, input bit quiet);
      logic [2*lsm_pkg::WORD_W-1:0] bytes;
      int                           used;
      int                           start;
      for (int k = 0; k < PATTERN_MAX; k++)
         bytes[8*k +: 8] = ($urandom_range(0, 99) < 60)
                         ? lsm_pkg::BYTE_W'(BYTE_LOWER_A + $urandom_range(0, 3))
                         : lsm_pkg::BYTE_W'($urandom_range(0, 255));
      set_pattern(bytes, len);
      used = (len > PATTERN_MAX) ? PATTERN_MAX : int'(len);
      idle_percent = quiet ? 0 : IDLE_PERCENT;
      start = items_queued;
      while (items_queued - start < RANDOM_PHASE_ITEMS) push_random_line(used, bytes);
      push_request(lsm_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
      wait_idle();
      idle_percent = IDLE_PERCENT;
   endtask

   initial begin : stimulus
      logic [2*lsm_pkg::WORD_W-1:0] long_pattern;
      pattern_low  = '0;
      pattern_high = '0;
      pattern_len  = lsm_pkg::LEN_W'(1);
      line_count   = lsm_pkg::COUNT_W'(1);
      match_count  = '0;
      clear_line();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset pattern is a single zero byte, which can never match
      push_text("ab");
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b0);
      push_request(lsm_pkg::BYTE_NUL, 1'b0);
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b1);
      wait_idle();

      // Short pattern: overlap, zero-byte close, empty line, short line, end mark
      set_pattern(pack_text("abc"), lsm_pkg::LEN_W'(3));
      push_text("xabcx");
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b0);
      push_text("ab");
      push_request(lsm_pkg::BYTE_NUL, 1'b0);
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b0);
      push_text("ababc");
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b0);
      push_request(8'hFF, 1'b0);
      push_request(8'h01, 1'b0);
      push_text("abc");
      push_request(8'h41, 1'b1);
      push_text("abc");
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b0);
      push_request(lsm_pkg::BYTE_NUL, 1'b1);
      wait_idle();

      // Empty pattern matches every line, the empty one too
      write_reg(lsm_pkg::REG_PATTERN_LEN, '0);
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b0);
      push_text("q");
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b0);
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b1);
      wait_idle();

      // Full-length pattern at the edge of the keep limit
      for (int k = 0; k < PATTERN_MAX; k++)
         long_pattern[8*k +: 8] = lsm_pkg::BYTE_W'($urandom_range(11, 254));
      long_pattern[7:0]  = 8'hFF;
      long_pattern[15:8] = 8'h01;
      set_pattern(long_pattern, lsm_pkg::LEN_W'(PATTERN_MAX));
      push_repeat(BYTE_FILL, LINE_KEEP - PATTERN_MAX);
      push_pattern(long_pattern, PATTERN_MAX);
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b0);
      push_repeat(BYTE_FILL, LINE_KEEP - PATTERN_MAX + 1);
      push_pattern(long_pattern, PATTERN_MAX);
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b0);
      push_pattern(long_pattern, PATTERN_MAX - 1);
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b0);
      wait_idle();

      // Lengths above the maximum act as the maximum; unmapped writes are dropped
      write_reg(lsm_pkg::REG_PATTERN_LEN, lsm_pkg::WORD_W'(31));
      push_pattern(long_pattern, PATTERN_MAX);
      push_request(lsm_pkg::BYTE_NEWLINE, 1'b0);
      wait_idle();
      write_reg(REG_UNMAPPED, {$urandom, $urandom});
      write_reg(lsm_pkg::REG_PATTERN_LEN, lsm_pkg::WORD_W'(17));
      push_text("zz");
      push_pattern(long_pattern, PATTERN_MAX);
      push_request(lsm_pkg::BYTE_NUL, 1'b0);
      push_request(BYTE_FILL, 1'b1);
      wait_idle();

      // Random files under a spread of pattern settings
      run_random_phase(lsm_pkg::LEN_W'(1), 1'b0);
      run_random_phase(lsm_pkg::LEN_W'(3), 1'b0);
      run_random_phase(lsm_pkg::LEN_W'(2), 1'b1);
      run_random_phase(lsm_pkg::LEN_W'(5), 1'b0);
      run_random_phase(lsm_pkg::LEN_W'(PATTERN_MAX), 1'b0);
      run_random_phase(lsm_pkg::LEN_W'(0), 1'b0);
      run_random_phase(lsm_pkg::LEN_W'(31), 1'b0);
      run_random_phase(lsm_pkg::LEN_W'($urandom_range(0, 31)), 1'b0);

      repeat (10) @(posedge clock);
      if (expected_lines.size() != 0) mismatch_count++;
      $display("Covered %0d requests and %0d line reports (%0d matching), %0d register writes,",
               requests_accepted, lines_checked, matched_lines, register_writes);
      $display("including keep-limit truncation, empty and oversize lengths and file restarts.");
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/lsm_pkg.sv
rtl/core/lsm_cell.sv
rtl/core/line_substring_matcher_core.sv
tb/line_substring_matcher_core_test.sv
